### rtl/glyph_cache_atlas_packer_macros.svh
// Assertion macros shared by the glyph cache RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef GLYPH_CACHE_ATLAS_PACKER_MACROS_SVH
`define GLYPH_CACHE_ATLAS_PACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCAP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCAP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gcap_pkg.sv
// Package of the glyph cache: sizes, status codes, slot layout and the
// command and status groups between controller and datapath. No dependencies.
package gcap_pkg;

    // Table size must be a power of two.
    localparam int TABLE_SLOTS = 1024;
    localparam int ATLAS_SIZE  = 512;
    localparam int GLYPH_GAP   = 1;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int GLYPH_LIMIT = ATLAS_SIZE - 2 * GLYPH_GAP;

    localparam logic [31:0] HASH_MUL   = 32'd2654435761;
    localparam int          HASH_SHIFT = 8;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    localparam int PEN_W = 11;
    localparam int SUM_W = 13;
    localparam logic [PEN_W-1:0] PEN_MAX = '1;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_NOT_IN_FONT= 3'd2,
        ST_TOO_LARGE  = 3'd3,
        ST_ATLAS_FULL = 3'd4,
        ST_TABLE_FULL = 3'd5,
        ST_INVALID    = 3'd6,
        ST_CLEARED    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_MEM   = 2'd1,
        SRC_EMPTY = 2'd2,
        SRC_PEN   = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        INS_ABSENT = 2'd0,
        INS_EMPTY  = 2'd1,
        INS_LARGE  = 2'd2,
        INS_FIT    = 2'd3
    } t_ins;

    typedef struct packed {
        logic [20:0]        code;
        logic [8:0]         ax;
        logic [8:0]         ay;
        logic [8:0]         w;
        logic [8:0]         h;
        logic signed [9:0]  bx;
        logic signed [9:0]  by;
        logic [15:0]        adv;
    } t_slot;

    typedef struct packed {
        logic    in_ready;
        logic    capture;
        logic    clr_start;
        logic    clr_step;
        logic    hash;
        logic    read;
        logic    probe_next;
        logic    shelf;
        logic    write_empty;
        logic    write_pen;
        logic    set_full;
        logic    res_load;
        t_status res_status;
        t_src    res_src;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic req_clear;
        logic req_bad;
        logic clr_last;
        logic code_match;
        logic code_empty;
        logic probe_last;
        t_ins ins_kind;
        logic place_full;
        logic out_free;
    } t_stat;

endpackage

### rtl/gcap_ifs.sv
// Channel interfaces of the glyph cache: request, configuration, response.
// No dependencies.
interface gcap_req_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [20:0]       codepoint;
    logic              glyph_present;
    logic [9:0]        bitmap_width;
    logic [9:0]        bitmap_height;
    logic signed [9:0] bearing_x;
    logic signed [9:0] bearing_y;
    logic [15:0]       advance;
    modport source (output valid, req_type, codepoint, glyph_present, bitmap_width,
                    bitmap_height, bearing_x, bearing_y, advance, input ready);
    modport sink   (input valid, req_type, codepoint, glyph_present, bitmap_width,
                    bitmap_height, bearing_x, bearing_y, advance, output ready);
endinterface

interface gcap_cfg_if;
    logic valid;
    logic ready;
    logic lookup_enable;
    modport source (output valid, lookup_enable, input ready);
    modport sink   (input valid, lookup_enable, output ready);
endinterface

interface gcap_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [8:0]        atlas_x;
    logic [8:0]        atlas_y;
    logic [8:0]        glyph_w;
    logic [8:0]        glyph_h;
    logic signed [9:0] glyph_bearing_x;
    logic signed [9:0] glyph_bearing_y;
    logic [15:0]       glyph_advance;
    logic              atlas_full_flag;
    logic [10:0]       cached_count;
    modport source (output valid, status, atlas_x, atlas_y, glyph_w, glyph_h,
                    glyph_bearing_x, glyph_bearing_y, glyph_advance, atlas_full_flag,
                    cached_count, input ready);
    modport sink   (input valid, status, atlas_x, atlas_y, glyph_w, glyph_h,
                    glyph_bearing_x, glyph_bearing_y, glyph_advance, atlas_full_flag,
                    cached_count, output ready);
endinterface

### rtl/gcap_dp.sv
// Datapath of the glyph cache: slot memory, hash, pen and shelf registers,
// result and output registers. Depends on gcap_pkg and gcap_ifs.
module gcap_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gcap_req_if.sink         i_req,
    gcap_cfg_if.sink         i_cfg,
    gcap_rsp_if.source       o_rsp,
    input  gcap_pkg::t_cmd   i_cmd,
    output gcap_pkg::t_stat  o_stat
);
    import gcap_pkg::*;

    t_slot r_mem [0:TABLE_SLOTS-1];
    t_slot r_rd;

    logic              r_lookup_en;
    logic [20:0]       r_cp;
    logic              r_present;
    logic [9:0]        r_bw;
    logic [9:0]        r_bh;
    logic signed [9:0] r_bx;
    logic signed [9:0] r_by;
    logic [15:0]       r_adv;

    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_probe;
    logic [IDX_W-1:0]  r_clr_idx;

    logic [PEN_W-1:0]  r_pen_x;
    logic [PEN_W-1:0]  r_pen_y;
    logic [9:0]        r_shelf;
    logic              r_full;
    logic [CNT_W-1:0]  r_count;

    t_slot             r_res;
    t_status           r_res_status;
    logic              r_out_valid;

    logic [52:0]       w_prod;
    logic [SUM_W-1:0]  w_row_end;
    logic [SUM_W-1:0]  w_col_end;
    logic [SUM_W-1:0]  w_next_row;
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_addr;
    t_slot             w_empty_slot;
    t_slot             w_pen_slot;
    t_ins              w_kind;

    function automatic logic [10:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+11:0] wide;
        wide = (CNT_W + 12)'(c);
        sat_count = (wide > (CNT_W + 12)'(2047)) ? 11'd2047 : wide[10:0];
    endfunction

    assign w_prod     = 53'(r_cp) * 53'(HASH_MUL);
    assign w_row_end  = SUM_W'(r_pen_x) + SUM_W'(r_bw) + SUM_W'(GLYPH_GAP);
    assign w_col_end  = SUM_W'(r_pen_y) + SUM_W'(r_bh) + SUM_W'(GLYPH_GAP);
    assign w_next_row = SUM_W'(r_pen_y) + SUM_W'(r_shelf) + SUM_W'(GLYPH_GAP);

    always_comb begin
        if (!r_present) begin
            w_kind = INS_ABSENT;
        end else if (r_bw == '0 || r_bh == '0) begin
            w_kind = INS_EMPTY;
        end else if (SUM_W'(r_bw) > SUM_W'(GLYPH_LIMIT) || SUM_W'(r_bh) > SUM_W'(GLYPH_LIMIT)) begin
            w_kind = INS_LARGE;
        end else begin
            w_kind = INS_FIT;
        end
    end

    always_comb begin
        w_empty_slot      = '0;
        w_empty_slot.code = r_cp;
        w_empty_slot.bx   = r_bx;
        w_empty_slot.by   = r_by;
        w_empty_slot.adv  = r_adv;
        w_pen_slot        = w_empty_slot;
        w_pen_slot.ax     = r_pen_x[8:0];
        w_pen_slot.ay     = r_pen_y[8:0];
        w_pen_slot.w      = r_bw[8:0];
        w_pen_slot.h      = r_bh[8:0];
    end

    assign w_mem_we   = i_cmd.clr_step || i_cmd.write_empty || i_cmd.write_pen;
    assign w_mem_addr = i_cmd.clr_step ? r_clr_idx : r_idx;

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            if (i_cmd.clr_step) begin
                r_mem[w_mem_addr] <= '0;
            end else if (i_cmd.write_pen) begin
                r_mem[w_mem_addr] <= w_pen_slot;
            end else begin
                r_mem[w_mem_addr] <= w_empty_slot;
            end
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // Captured request, probe and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cp      <= i_req.codepoint;
            r_present <= i_req.glyph_present;
            r_bw      <= i_req.bitmap_width;
            r_bh      <= i_req.bitmap_height;
            r_bx      <= i_req.bearing_x;
            r_by      <= i_req.bearing_y;
            r_adv     <= i_req.advance;
        end
        if (i_cmd.hash) begin
            r_idx   <= w_prod[HASH_SHIFT +: IDX_W];
            r_probe <= '0;
        end else if (i_cmd.probe_next) begin
            r_idx   <= r_idx + 1'b1;
            r_probe <= r_probe + 1'b1;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_src)
                SRC_MEM:   r_res <= r_rd;
                SRC_EMPTY: r_res <= w_empty_slot;
                SRC_PEN:   r_res <= w_pen_slot;
                default:   r_res <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup_en <= 1'b1;
            r_clr_idx   <= '0;
            r_pen_x     <= PEN_W'(GLYPH_GAP);
            r_pen_y     <= PEN_W'(GLYPH_GAP);
            r_shelf     <= '0;
            r_full      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_lookup_en <= i_cfg.lookup_enable;
            end
            if (i_cmd.clr_start) begin
                r_clr_idx <= '0;
                r_pen_x   <= PEN_W'(GLYPH_GAP);
                r_pen_y   <= PEN_W'(GLYPH_GAP);
                r_shelf   <= '0;
                r_full    <= 1'b0;
                r_count   <= '0;
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            // A new shelf opens when the glyph overruns the right edge.
            if (i_cmd.shelf && w_row_end > SUM_W'(ATLAS_SIZE)) begin
                r_pen_x <= PEN_W'(GLYPH_GAP);
                r_pen_y <= (w_next_row > SUM_W'(PEN_MAX)) ? PEN_MAX : w_next_row[PEN_W-1:0];
                r_shelf <= '0;
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.write_pen) begin
                r_pen_x <= r_pen_x + PEN_W'(r_bw) + PEN_W'(GLYPH_GAP);
                if (r_bh > r_shelf) begin
                    r_shelf <= r_bh;
                end
            end
            if (i_cmd.write_empty || i_cmd.write_pen) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register; flags and count are taken as they stand after the item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_rsp.status          <= r_res_status;
            o_rsp.atlas_x         <= r_res.ax;
            o_rsp.atlas_y         <= r_res.ay;
            o_rsp.glyph_w         <= r_res.w;
            o_rsp.glyph_h         <= r_res.h;
            o_rsp.glyph_bearing_x <= r_res.bx;
            o_rsp.glyph_bearing_y <= r_res.by;
            o_rsp.glyph_advance   <= r_res.adv;
            o_rsp.atlas_full_flag <= r_full;
            o_rsp.cached_count    <= sat_count(r_count);
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        o_stat.req_valid  = i_req.valid;
        o_stat.req_clear  = i_req.req_type;
        o_stat.req_bad    = !r_lookup_en || i_req.codepoint == '0 || i_req.codepoint > CP_MAX;
        o_stat.clr_last   = r_clr_idx == IDX_W'(TABLE_SLOTS - 1);
        o_stat.code_match = r_rd.code == r_cp;
        o_stat.code_empty = r_rd.code == '0;
        o_stat.probe_last = r_probe == IDX_W'(TABLE_SLOTS - 1);
        o_stat.ins_kind   = w_kind;
        o_stat.place_full = w_col_end > SUM_W'(ATLAS_SIZE);
        o_stat.out_free   = !r_out_valid || o_rsp.ready;
    end

endmodule

### rtl/gcap_ctrl.sv
// Controller of the glyph cache: one-hot state machine that sequences
// clearing, hashing, probing and placement. Depends on gcap_pkg and the macros.
`include "glyph_cache_atlas_packer_macros.svh"

module gcap_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gcap_pkg::t_stat  i_stat,
    output gcap_pkg::t_cmd   o_cmd
);
    import gcap_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_INS   = 8'b0010_0000,
        S_PLACE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_item, n_clr_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_clr_item = r_clr_item;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    if (r_clr_item) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_CLEARED;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.req_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.req_clear) begin
                        o_cmd.clr_start = 1'b1;
                        n_clr_item      = 1'b1;
                        n_state         = S_CLEAR;
                    end else if (i_stat.req_bad) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_INVALID;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.code_match) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_HIT;
                    o_cmd.res_src    = SRC_MEM;
                    n_state          = S_DONE;
                end else if (i_stat.code_empty) begin
                    n_state = S_INS;
                end else if (i_stat.probe_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_TABLE_FULL;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_READ;
                end
            end
            S_INS: begin
                n_state = S_DONE;
                case (i_stat.ins_kind)
                    INS_ABSENT: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_NOT_IN_FONT;
                    end
                    INS_EMPTY: begin
                        o_cmd.write_empty = 1'b1;
                        o_cmd.res_load    = 1'b1;
                        o_cmd.res_status  = ST_INSERTED;
                        o_cmd.res_src     = SRC_EMPTY;
                    end
                    INS_LARGE: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_TOO_LARGE;
                    end
                    default: begin
                        o_cmd.shelf = 1'b1;
                        n_state     = S_PLACE;
                    end
                endcase
            end
            S_PLACE: begin
                o_cmd.res_load = 1'b1;
                n_state        = S_DONE;
                if (i_stat.place_full) begin
                    o_cmd.set_full   = 1'b1;
                    o_cmd.res_status = ST_ATLAS_FULL;
                end else begin
                    o_cmd.write_pen  = 1'b1;
                    o_cmd.res_status = ST_INSERTED;
                    o_cmd.res_src    = SRC_PEN;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_clr_item = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `GCAP_ASSERT_NXT(a_clear_starts_sweep, r_state == S_IDLE && i_stat.req_valid && i_stat.req_clear, r_state == S_CLEAR && r_clr_item, "accepted clear did not start the sweep")
    `GCAP_ASSERT_NXT(a_hit_completes, r_state == S_CHECK && i_stat.code_match, r_state == S_DONE, "hit did not complete")
    `GCAP_ASSERT_IMP(a_write_in_place, o_cmd.write_empty || o_cmd.write_pen, r_state == S_INS || r_state == S_PLACE, "slot written outside placement")
    `GCAP_ASSERT_IMP(a_emit_only_free, o_cmd.emit, i_stat.out_free && r_state == S_DONE, "result emitted into a busy output")

endmodule

### rtl/glyph_cache_atlas_packer.sv
// Top level of the glyph cache with shelf-packed atlas placement.
// Depends on gcap_pkg, gcap_ifs, gcap_ctrl and gcap_dp.
//
//   Channel  Dir  Handshake     Carries
//   i_req    in   valid/ready   request type, codepoint, glyph metrics
//   i_cfg    in   valid/ready   lookup_enable register write
//   o_rsp    out  valid/ready   status, placement, metrics, flag, count
//
// Sequence: a hit on the first probe passes HASH, READ, CHECK and DONE from
// acceptance to the output register; each further probe adds a READ and a CHECK
// state, set by the single read port of the slot memory and its registered read
// data. A placed miss adds the INS and PLACE states. Reset and clear requests
// run a clearing pass through the slot memory, one entry per cycle; no request
// is taken meanwhile, while configuration writes are taken at any time.
// One request is in flight at a time; a finished result waits in the output
// register, and the next request is taken once the result has left the
// internal result register.
module glyph_cache_atlas_packer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcap_req_if.sink   i_req,
    gcap_cfg_if.sink   i_cfg,
    gcap_rsp_if.source o_rsp
);
    import gcap_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller sequences the work; the datapath owns every register
    // that holds payload, the slot memory and the channels.
    gcap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gcap_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule
